>>> rtl/core/ggc_pkg.sv
// Shared types, constants and helpers of the greedy graph coloring engine.
// Used by rtl/core/greedy_graph_coloring_engine.sv; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ggc_pkg;

    // Graph size and field widths.
    localparam int NumVertices = 16;
    localparam int VtxW        = 4;
    localparam int ColorW      = 4;
    localparam int CountW      = 5;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_DFS  = 2'd1;
    localparam logic [1:0] MODE_BFS  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_SCAN,
        ST_COL_EMIT,
        ST_DFS_SCAN,
        ST_DFS_LOAD,
        ST_BFS_POP,
        ST_BFS_SCAN,
        ST_OUTER
    } state_t;

    // Lowest color whose bit is clear in the taken set.
    function automatic logic [ColorW-1:0] lowest_free(input logic [NumVertices-1:0] taken);
        logic [ColorW-1:0] c;
        c = '0;
        for (int k = NumVertices - 1; k >= 0; k--) begin
            if (!taken[k]) begin
                c = ColorW'(k);
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/greedy_graph_coloring_engine.sv
// Greedy graph coloring engine: adjacency store, walk sequencer and result register.
// Depends on rtl/core/ggc_pkg.sv.
//
// Usage: items enter on the s_axis channel. tuser selects the kind of item: a row
// load (0) writes the adjacency row named by row_index, a depth-first (1) or
// breadth-first (2) run colors the whole graph starting at start_vertex, and kind 3
// is dropped. A run gives one result item per vertex on the
// m_axis channel, in visit order; the final one has tlast set and carries the
// number of colors used. s_axis_tready is high only while the sequencer is idle.
// Each vertex is colored by a scan of its row and neighbor colors on the shared
// scan path, one row bit and one stored color per cycle, then an emit step. Each
// walk step scans one neighbor per cycle, with a stack reload or queue pop between
// rows, and a restart pass looks for vertices not yet visited.
// A stalled receiver holds the result register and the sequencer waits in its
// emit step until the register frees. Reset clears the sequencer, the marks and
// the result valid flag; adjacency rows hold no value until loaded.
`timescale 1ns / 1ps
`default_nettype none
module greedy_graph_coloring_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // row_index[3:0], row_bits[19:4], start_vertex[23:20]
    input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // vertex[3:0], color[7:4], colors_used[12:8], zero
    output logic             m_axis_tlast   // last
);

    localparam int NV = ggc_pkg::NumVertices;
    localparam int VW = ggc_pkg::VtxW;
    localparam int CW = ggc_pkg::ColorW;
    localparam int NW = ggc_pkg::CountW;

    ggc_pkg::state_t state_reg, state_next;

    // Storage.
    logic [NV-1:0] adj_mem [NV];
    logic [CW-1:0] col_mem [NV];
    logic [VW-1:0] stk_v_mem [NV];
    logic [NW-1:0] stk_n_mem [NV];
    logic [VW-1:0] queue_mem [NV];

    // Control and walk registers.
    logic [NV-1:0] vis_reg;
    logic [NV-1:0] taken_reg;
    logic [CW-1:0] maxc_reg;
    logic [VW-1:0] emitted_reg;
    logic          dfs_reg;
    logic          start_reg;
    logic [VW-1:0] cv_reg;
    logic [VW-1:0] cj_reg;
    logic [VW-1:0] wv_reg;
    logic [NW-1:0] jj_reg;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] head_reg;
    logic [NW-1:0] tail_reg;
    logic [NW-1:0] outer_reg;
    logic          out_valid_reg;
    logic [15:0]   out_data_reg;
    logic          out_last_reg;

    // Input fields.
    logic [1:0]    in_mode;
    logic [VW-1:0] in_row_index;
    logic [NV-1:0] in_row_bits;
    logic [VW-1:0] in_start;
    logic          in_fire;

    // Shared scan path.
    logic [VW-1:0] adj_addr;
    logic [NV-1:0] adj_row;
    logic          scan_end;
    logic          scan_hit;
    logic [CW-1:0] new_color;
    logic [CW-1:0] top_color;
    logic          emit_fire;
    logic [NW-1:0] top_idx;

    assign in_mode      = s_axis_tuser;
    assign in_row_index = s_axis_tdata[3:0];
    assign in_row_bits  = s_axis_tdata[19:4];
    assign in_start     = s_axis_tdata[23:20];
    assign s_axis_tready = (state_reg == ggc_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign adj_addr  = (state_reg == ggc_pkg::ST_COL_SCAN) ? cv_reg : wv_reg;
    assign adj_row   = adj_mem[adj_addr];
    assign scan_end  = jj_reg[NW-1];
    assign scan_hit  = adj_row[jj_reg[VW-1:0]] && !vis_reg[jj_reg[VW-1:0]];
    assign new_color = ggc_pkg::lowest_free(taken_reg);
    assign top_color = (new_color > maxc_reg) ? new_color : maxc_reg;
    assign emit_fire = (state_reg == ggc_pkg::ST_COL_EMIT) && (!out_valid_reg || m_axis_tready);
    assign top_idx   = count_reg - NW'(1);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ggc_pkg::ST_IDLE:
            begin
                if (in_fire && (in_mode == ggc_pkg::MODE_DFS || in_mode == ggc_pkg::MODE_BFS))
                begin
                    state_next = ggc_pkg::ST_COL_SCAN;
                end
            end
            ggc_pkg::ST_COL_SCAN:
            begin
                if (cj_reg == VW'(NV - 1))
                begin
                    state_next = ggc_pkg::ST_COL_EMIT;
                end
            end
            ggc_pkg::ST_COL_EMIT:
            begin
                if (emit_fire)
                begin
                    if (dfs_reg)
                    begin
                        state_next = ggc_pkg::ST_DFS_SCAN;
                    end
                    else if (start_reg)
                    begin
                        state_next = ggc_pkg::ST_BFS_POP;
                    end
                    else
                    begin
                        state_next = ggc_pkg::ST_BFS_SCAN;
                    end
                end
            end
            ggc_pkg::ST_DFS_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (count_reg == NW'(1)) ? ggc_pkg::ST_OUTER : ggc_pkg::ST_DFS_LOAD;
                end
                else if (scan_hit)
                begin
                    state_next = ggc_pkg::ST_COL_SCAN;
                end
            end
            ggc_pkg::ST_DFS_LOAD:
            begin
                state_next = ggc_pkg::ST_DFS_SCAN;
            end
            ggc_pkg::ST_BFS_POP:
            begin
                state_next = (head_reg == tail_reg) ? ggc_pkg::ST_OUTER : ggc_pkg::ST_BFS_SCAN;
            end
            ggc_pkg::ST_BFS_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ggc_pkg::ST_BFS_POP;
                end
                else if (scan_hit)
                begin
                    state_next = ggc_pkg::ST_COL_SCAN;
                end
            end
            ggc_pkg::ST_OUTER:
            begin
                if (outer_reg[NW-1])
                begin
                    state_next = ggc_pkg::ST_IDLE;
                end
                else if (!vis_reg[outer_reg[VW-1:0]])
                begin
                    state_next = ggc_pkg::ST_COL_SCAN;
                end
            end
            default:
            begin
                state_next = ggc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and walk pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ggc_pkg::ST_IDLE;
            vis_reg       <= '0;
            maxc_reg      <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            outer_reg     <= '0;
            start_reg     <= 1'b0;
            dfs_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // The result register fills on an emit and drains when the receiver takes it.
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ggc_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        vis_reg     <= '0;
                        maxc_reg    <= '0;
                        emitted_reg <= '0;
                        outer_reg   <= '0;
                        count_reg   <= '0;
                        head_reg    <= '0;
                        tail_reg    <= '0;
                        start_reg   <= 1'b1;
                        dfs_reg     <= (in_mode == ggc_pkg::MODE_DFS);
                    end
                end
                ggc_pkg::ST_COL_EMIT:
                begin
                    if (emit_fire)
                    begin
                        vis_reg[cv_reg] <= 1'b1;
                        maxc_reg      <= top_color;
                        emitted_reg   <= emitted_reg + VW'(1);
                        start_reg     <= 1'b0;
                        if (dfs_reg)
                        begin
                            if (count_reg < NW'(NV))
                            begin
                                count_reg <= count_reg + NW'(1);
                            end
                        end
                        else if (tail_reg < NW'(NV))
                        begin
                            tail_reg <= tail_reg + NW'(1);
                        end
                    end
                end
                ggc_pkg::ST_DFS_SCAN:
                begin
                    if (scan_end)
                    begin
                        count_reg <= top_idx;
                    end
                end
                ggc_pkg::ST_BFS_POP:
                begin
                    if (head_reg != tail_reg)
                    begin
                        head_reg <= head_reg + NW'(1);
                    end
                end
                ggc_pkg::ST_OUTER:
                begin
                    if (!outer_reg[NW-1])
                    begin
                        outer_reg <= outer_reg + NW'(1);
                        if (!vis_reg[outer_reg[VW-1:0]])
                        begin
                            start_reg <= 1'b1;
                            count_reg <= '0;
                            head_reg  <= '0;
                            tail_reg  <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Scan registers and the result payload.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ggc_pkg::ST_IDLE:
            begin
                cv_reg    <= in_start;
                cj_reg    <= '0;
                taken_reg <= '0;
            end
            ggc_pkg::ST_COL_SCAN:
            begin
                cj_reg <= cj_reg + VW'(1);
                if (adj_row[cj_reg] && vis_reg[cj_reg])
                begin
                    taken_reg[col_mem[cj_reg]] <= 1'b1;
                end
            end
            ggc_pkg::ST_COL_EMIT:
            begin
                if (emit_fire)
                begin
                    out_data_reg <= {3'b000,
                                     (emitted_reg == VW'(NV - 1)) ? NW'(top_color) + NW'(1) : NW'(0),
                                     new_color, cv_reg};
                    out_last_reg <= (emitted_reg == VW'(NV - 1));
                    if (dfs_reg)
                    begin
                        wv_reg <= cv_reg;
                        jj_reg <= '0;
                    end
                    else
                    begin
                        jj_reg <= jj_reg + NW'(1);
                    end
                end
            end
            ggc_pkg::ST_DFS_SCAN, ggc_pkg::ST_BFS_SCAN:
            begin
                if (!scan_end)
                begin
                    if (scan_hit)
                    begin
                        cv_reg    <= jj_reg[VW-1:0];
                        cj_reg    <= '0;
                        taken_reg <= '0;
                    end
                    else
                    begin
                        jj_reg <= jj_reg + NW'(1);
                    end
                end
            end
            ggc_pkg::ST_DFS_LOAD:
            begin
                wv_reg <= stk_v_mem[top_idx[VW-1:0]];
                jj_reg <= stk_n_mem[top_idx[VW-1:0]];
            end
            ggc_pkg::ST_BFS_POP:
            begin
                wv_reg <= queue_mem[head_reg[VW-1:0]];
                jj_reg <= '0;
            end
            ggc_pkg::ST_OUTER:
            begin
                cv_reg    <= outer_reg[VW-1:0];
                cj_reg    <= '0;
                taken_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // Adjacency rows, vertex colors, walk stack and walk queue.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_mode == ggc_pkg::MODE_LOAD)
        begin
            adj_mem[in_row_index] <= in_row_bits;
        end
        if (emit_fire)
        begin
            col_mem[cv_reg] <= new_color;
            if (dfs_reg && count_reg < NW'(NV))
            begin
                stk_v_mem[count_reg[VW-1:0]] <= cv_reg;
            end
            if (!dfs_reg && tail_reg < NW'(NV))
            begin
                queue_mem[tail_reg[VW-1:0]] <= cv_reg;
            end
        end
        if (state_reg == ggc_pkg::ST_DFS_SCAN && !scan_end && scan_hit)
        begin
            stk_n_mem[top_idx[VW-1:0]] <= jj_reg + NW'(1);
        end
    end

`ifndef SYNTH
    // The stack never holds more frames than vertices.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= NW'(NV))
        else $error("walk stack overflow");

    // Only the final result of a run carries a color count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[12:8] == 5'd0)
        else $error("color count on a non-final result");

    // An emitted vertex is marked visited right after.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> vis_reg[$past(cv_reg)])
        else $error("emitted vertex not marked");
`endif

endmodule
`default_nettype wire

>>> test/ggc_checker.sv
// Result checker for the greedy graph coloring engine: watches both streams,
// predicts the colored walk of each run item and compares every result item.
// Depends on rtl/core/ggc_pkg.sv.
`timescale 1ns / 1ps
module ggc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [ggc_pkg::VtxW-1:0]   vertex;
        logic [ggc_pkg::ColorW-1:0] color;
        logic [ggc_pkg::CountW-1:0] colors_used;
        logic                       last;
    } coloring_t;

    logic [ggc_pkg::NumVertices-1:0] adj_rows [ggc_pkg::NumVertices];
    logic [ggc_pkg::NumVertices-1:0] seen;
    logic [ggc_pkg::ColorW-1:0]      hue [ggc_pkg::NumVertices];
    logic [ggc_pkg::ColorW-1:0]      top_hue;
    coloring_t                       walk_q [$];
    int                              mismatches;

    // Gives v the lowest color free among its colored neighbors and queues its result.
    task automatic paint(input int v);
        logic [ggc_pkg::NumVertices-1:0] taken;
        int c;
        taken = '0;
        c = 0;
        for (int j = 0; j < ggc_pkg::NumVertices; j++)
        begin
            if (adj_rows[v][j] && seen[j])
            begin
                taken[hue[j]] = 1'b1;
            end
        end
        while (c < ggc_pkg::NumVertices && taken[c])
        begin
            c++;
        end
        hue[v] = ggc_pkg::ColorW'(c);
        seen[v] = 1'b1;
        if (ggc_pkg::ColorW'(c) > top_hue)
        begin
            top_hue = ggc_pkg::ColorW'(c);
        end
        walk_q.push_back('{ggc_pkg::VtxW'(v), ggc_pkg::ColorW'(c), '0, 1'b0});
    endtask

    // Depth-first walk with an explicit frame stack of vertex and next neighbor.
    task automatic walk_deep(input int s);
        int fv [ggc_pkg::NumVertices];
        int fn [ggc_pkg::NumVertices];
        int sp;
        int v;
        int j;
        paint(s);
        sp = 0;
        fv[0] = s;
        fn[0] = 0;
        while (sp >= 0)
        begin
            v = fv[sp];
            j = fn[sp];
            while (j < ggc_pkg::NumVertices && !(adj_rows[v][j] && !seen[j]))
            begin
                j++;
            end
            if (j >= ggc_pkg::NumVertices)
            begin
                sp--;
            end
            else
            begin
                fn[sp] = j + 1;
                paint(j);
                if (sp + 1 < ggc_pkg::NumVertices)
                begin
                    sp++;
                    fv[sp] = j;
                    fn[sp] = 0;
                end
            end
        end
    endtask

    // Breadth-first walk through a bounded FIFO.
    task automatic walk_wide(input int s);
        int fifo [ggc_pkg::NumVertices];
        int head;
        int tail;
        int v;
        head = 0;
        tail = 0;
        paint(s);
        fifo[tail++] = s;
        while (head < tail)
        begin
            v = fifo[head++];
            for (int j = 0; j < ggc_pkg::NumVertices; j++)
            begin
                if (adj_rows[v][j] && !seen[j])
                begin
                    paint(j);
                    if (tail < ggc_pkg::NumVertices)
                    begin
                        fifo[tail++] = j;
                    end
                end
            end
        end
    endtask

    // Colors the whole graph for one run item.
    task automatic predict_run(input logic [1:0] mode, input int s);
        seen = '0;
        top_hue = '0;
        if (mode == ggc_pkg::MODE_DFS) walk_deep(s); else walk_wide(s);
        for (int i = 0; i < ggc_pkg::NumVertices; i++)
        begin
            if (!seen[i])
            begin
                if (mode == ggc_pkg::MODE_DFS) walk_deep(i); else walk_wide(i);
            end
        end
        walk_q[walk_q.size() - 1].colors_used = ggc_pkg::CountW'(top_hue) + 1'b1;
        walk_q[walk_q.size() - 1].last = 1'b1;
    endtask

    assign pending = walk_q.size();

    // Watch both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        coloring_t want;
        coloring_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            mismatches = 0;
            walk_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == ggc_pkg::MODE_LOAD)
                begin
                    adj_rows[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
                end
                else if (s_axis_tuser == ggc_pkg::MODE_DFS || s_axis_tuser == ggc_pkg::MODE_BFS)
                begin
                    predict_run(s_axis_tuser, int'(s_axis_tdata[23:20]));
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tdata[12:8],
                        m_axis_tlast};
                if (walk_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result item %p", got);
                end
                else
                begin
                    want = walk_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: expected %p got %p", want, got);
                    end
                end
            end
            fail_count <= mismatches;
        end
    end

endmodule

>>> test/tb_greedy_graph_coloring_engine.sv
// Testbench top for the greedy graph coloring engine: loads graphs, issues
// colored walks with random stalls, and reports the verdict of ggc_checker.
// Depends on rtl/core/ggc_pkg.sv, the engine and test/ggc_checker.sv.
`timescale 1ns / 1ps
module tb_greedy_graph_coloring_engine;

    localparam int WatchLimit = 40000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          sent_items;
    int          runs_sent;
    bit          calm;

    greedy_graph_coloring_engine i_dut (.*);

    ggc_checker i_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver stalls in random bursts until the final stretch.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit)
        begin
            $display("FAIL greedy_graph_coloring_engine");
            $finish;
        end
    end

    // Sends one item and waits until it is accepted; valid stays up for the next item.
    task automatic send(input logic [1:0] mode, input logic [3:0] row,
                        input logic [15:0] bits, input logic [3:0] start);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {start, bits, row};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        sent_items++;
        if (mode == ggc_pkg::MODE_DFS || mode == ggc_pkg::MODE_BFS) runs_sent++;
    endtask

    // Loads a whole random graph; style picks sparse, dense or symmetric rows.
    task automatic load_graph(input int style);
        logic [15:0] rows [16];
        for (int r = 0; r < 16; r++)
        begin
            case (style)
                0: rows[r] = 16'($urandom) & 16'($urandom) & 16'($urandom);
                1: rows[r] = 16'($urandom) | 16'($urandom);
                default: rows[r] = 16'($urandom);
            endcase
        end
        if (style == 2)
        begin
            for (int r = 0; r < 16; r++)
                for (int c = 0; c < r; c++)
                    rows[c][r] = rows[r][c];
        end
        for (int r = 0; r < 16; r++)
            send(ggc_pkg::MODE_LOAD, 4'(r), rows[r], 4'($urandom));
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ggc_pkg::MODE_LOAD;
        rst_n         = 1'b0;
        idle_cycles   = 0;
        sent_items    = 0;
        runs_sent     = 0;
        calm          = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty graph, full graph with self loops, path, ignored kind.
        for (int r = 0; r < 16; r++) send(ggc_pkg::MODE_LOAD, 4'(r), 16'h0000, 4'hF);
        send(ggc_pkg::MODE_DFS, 4'hF, 16'hFFFF, 4'h0);
        send(ggc_pkg::MODE_BFS, 4'h0, 16'h0000, 4'hF);
        send(2'd3, 4'hA, 16'hAAAA, 4'h5);
        for (int r = 0; r < 16; r++) send(ggc_pkg::MODE_LOAD, 4'(r), 16'hFFFF, 4'h0);
        send(ggc_pkg::MODE_DFS, 4'h0, 16'h5555, 4'hF);
        send(ggc_pkg::MODE_BFS, 4'h0, 16'h0000, 4'h7);
        for (int r = 0; r < 16; r++)
            send(ggc_pkg::MODE_LOAD, 4'(r), 16'((32'h1 << (r + 1)) | (32'h1 << r >> 1)), 4'h0);
        send(ggc_pkg::MODE_DFS, 4'h0, 16'h0000, 4'h8);
        send(ggc_pkg::MODE_BFS, 4'h0, 16'hFFFF, 4'h3);

        // Pause until every expected result has come back.
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        // Random graphs, each followed by one to four items, mostly walks, some noise.
        while (sent_items < 370)
        begin
            if (sent_items > 300) calm = 1'b1;
            load_graph($urandom_range(0, 2));
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9))
                    0: send(2'd3, 4'($urandom), 16'($urandom), 4'($urandom));
                    1: send(ggc_pkg::MODE_LOAD, 4'($urandom), 16'($urandom), 4'($urandom));
                    default: send($urandom_range(0, 1) ? ggc_pkg::MODE_DFS : ggc_pkg::MODE_BFS,
                                  4'($urandom), 16'($urandom), 4'($urandom));
                endcase
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (600) @(posedge clk);
        $display("Sent %0d items including %0d colored walks over sparse, dense", sent_items,
                 runs_sent);
        $display("and symmetric graphs, with stalls on both streams.");
        if (fail_count == 0)
            $display("PASS greedy_graph_coloring_engine");
        else
            $display("FAIL greedy_graph_coloring_engine");
        $finish;
    end

endmodule
